// ===== rtl/stf_pkg.sv =====
// Shared constants for the sort-then-snake-fill block.
// Depends on nothing; imported by the top level.
package stf_pkg;

   localparam int MAX_ROWS    = 8;
   localparam int MAX_COLS    = 8;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int DIM_W       = 4;
   localparam int POS_W       = 3;
   localparam int VALUE_W     = 32;
   localparam int RSP_DATA_W  = 40;

   // Register indexes on the csr port
   localparam logic [1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [1:0] REG_COL_COUNT = 2'd1;
   localparam logic [1:0] REG_FILL_MODE = 2'd2;

   localparam logic MODE_ROWS = 1'b0;
   localparam logic MODE_COLS = 1'b1;

endpackage

// ===== rtl/sort_then_snake_fill.sv =====
// Loads a matrix of signed values, keeps them sorted, then emits them in snake order.
// Depends on stf_pkg for sizes, register indexes and mode codes.
//
// Insertion: each accepted request walks the one-port store down from the top, moving every
// stored value greater than it up one slot; req_tready stays low until the walk ends. The
// request that completes the matrix then emits total responses, one at a time, each held
// until rsp_tready is high; no request is taken during emission.
// Reset: synchronous, active high; row_count and col_count 1, fill_mode 0, load count 0.
// The element store is not cleared: only entries written in the current load are read.
module sort_then_snake_fill
   import stf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // [31:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] value_res, [34:32] row, [37:35] col
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHIFT = 3'd1;
   localparam logic [2:0] S_PUT   = 3'd2;
   localparam logic [2:0] S_ERD   = 3'd3;
   localparam logic [2:0] S_ELOAD = 3'd4;
   localparam logic [2:0] S_EWAIT = 3'd5;

   // Configuration registers
   logic [DIM_W-1:0] row_count_ff, col_count_ff;
   logic             fill_mode_ff;

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [POS_W-1:0]  minor_ff, minor_in, major_ff, major_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic signed [VALUE_W-1:0] v_ff, v_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]          rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Element store
   logic [VALUE_W-1:0]  store_mem [STORE_DEPTH];
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic                wr_en;

   logic [DIM_W-1:0]    eff_rows, eff_cols, minor_len;
   logic [2*DIM_W-1:0]  product;
   logic [CNT_W-1:0]    total, count_next;
   logic                req_fire, rsp_fire, greater, last_item;
   logic [DIM_W-1:0]    rev_pos;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Clamp the dimensions into the supported range
   always_comb begin
      if (row_count_ff == '0) begin
         eff_rows = DIM_W'(1);
      end else if (row_count_ff > DIM_W'(MAX_ROWS)) begin
         eff_rows = DIM_W'(MAX_ROWS);
      end else begin
         eff_rows = row_count_ff;
      end
      if (col_count_ff == '0) begin
         eff_cols = DIM_W'(1);
      end else if (col_count_ff > DIM_W'(MAX_COLS)) begin
         eff_cols = DIM_W'(MAX_COLS);
      end else begin
         eff_cols = col_count_ff;
      end
   end

   assign product    = eff_rows * eff_cols;
   assign total      = product[CNT_W-1:0];
   assign count_next = count_ff + CNT_W'(1);
   assign greater    = $signed(rd_data_ff) > v_ff;
   assign minor_len  = (fill_mode_ff == MODE_COLS) ? eff_rows : eff_cols;
   assign rev_pos    = minor_len - DIM_W'(1) - DIM_W'(minor_ff);
   assign last_item  = ({1'b0, k_ff} == total - CNT_W'(1));

   // Pick the store read address for the current phase
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = count_ff[ADDR_W-1:0] - ADDR_W'(1);
         S_SHIFT: rd_addr = j_ff - ADDR_W'(2);
         default: rd_addr = k_ff;
      endcase
   end

   // Sequencer: insertion on load, then paced emission
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      minor_in     = minor_ff;
      major_in     = major_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = j_ff;
      wr_data      = v_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               v_in = req_tdata;
               j_in = count_ff[ADDR_W-1:0];
               if (count_ff == '0) begin
                  j_in     = '0;
                  state_in = S_PUT;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // Move a larger neighbor up one slot, or drop the new value in place
            if (greater) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = rd_data_ff;
               j_in    = j_ff - ADDR_W'(1);
               if (j_ff == ADDR_W'(1)) begin
                  state_in = S_PUT;
               end
            end else begin
               wr_en = 1'b1;
               if (count_next >= total) begin
                  count_in = '0;
                  k_in     = '0;
                  minor_in = '0;
                  major_in = '0;
                  state_in = S_ERD;
               end else begin
                  count_in = count_next;
                  state_in = S_IDLE;
               end
            end
         end
         S_PUT: begin
            wr_en = 1'b1;
            if (count_next >= total) begin
               count_in = '0;
               k_in     = '0;
               minor_in = '0;
               major_in = '0;
               state_in = S_ERD;
            end else begin
               count_in = count_next;
               state_in = S_IDLE;
            end
         end
         S_ERD: begin
            state_in = S_ELOAD;
         end
         S_ELOAD: begin
            // Load the response register and advance the snake position
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data_ff;
            rsp_last_in  = last_item;
            if (fill_mode_ff == MODE_COLS) begin
               rsp_col_in = major_ff;
               rsp_row_in = major_ff[0] ? rev_pos[POS_W-1:0] : minor_ff;
            end else begin
               rsp_row_in = major_ff;
               rsp_col_in = major_ff[0] ? rev_pos[POS_W-1:0] : minor_ff;
            end
            k_in = k_ff + ADDR_W'(1);
            if (DIM_W'(minor_ff) + DIM_W'(1) == minor_len) begin
               minor_in = '0;
               major_in = major_ff + POS_W'(1);
            end else begin
               minor_in = minor_ff + POS_W'(1);
            end
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? S_IDLE : S_ELOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= DIM_W'(1);
         col_count_ff <= DIM_W'(1);
         fill_mode_ff <= MODE_ROWS;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         // Any known register write abandons a partial load
         if (csr_we) begin
            case (csr_addr)
               REG_ROW_COUNT: begin
                  row_count_ff <= csr_wdata;
                  count_ff     <= '0;
               end
               REG_COL_COUNT: begin
                  col_count_ff <= csr_wdata;
                  count_ff     <= '0;
               end
               REG_FILL_MODE: begin
                  fill_mode_ff <= csr_wdata[0];
                  count_ff     <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      k_ff         <= k_in;
      minor_ff     <= minor_in;
      major_ff     <= major_in;
      v_ff         <= v_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Checks
   a_rsp_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_EWAIT)
      else $error("response valid outside emission wait");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_count_below_total: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> count_ff < total)
      else $error("load count reached matrix size while idle");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> j_ff != '0)
      else $error("insertion walk below slot zero");

   a_emit_from_insert: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ERD |-> $past(state_ff) == S_SHIFT || $past(state_ff) == S_PUT)
      else $error("emission started without a completed load");

endmodule

// ===== bench/tb_sort_then_snake_fill.sv =====
// Self-checking bench for sort_then_snake_fill: loads matrices, predicts the sorted
// snake placement of every value and compares each response field by field.
// Depends on stf_pkg and the sort_then_snake_fill RTL; nothing else.
module tb_sort_then_snake_fill
   import stf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 1;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 80;     // outlasts the worst insertion walk
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_VALUES  = 120;
   localparam int SNAKE_PERIOD   = 2;
   localparam logic [1:0] REG_UNUSED = 2'd3;   // index past fill_mode, ignored

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          row;
      logic [POS_W-1:0]          col;
      logic                      last;
   } placement_type;

   typedef enum logic {STIM_WRITE, STIM_VALUE} stim_kind_type;

   typedef struct {
      stim_kind_type    kind;
      logic [1:0]       addr;
      logic [DIM_W-1:0] wdata;
      logic [31:0]      value;
      bit               fixed;   // response typed in below, not predicted
      placement_type    fixed_res;
   } stim_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_PATTERN, READY_COIN, READY_DENSE
   } ready_style_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata;    // [31:0] value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [31:0] value_res, [34:32] row, [37:35] col
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [1:0]            csr_addr;
   logic [DIM_W-1:0]      csr_wdata;

   sort_then_snake_fill dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow copy of the block's registers and load buffer
   logic [DIM_W-1:0]          shadow_rows;
   logic [DIM_W-1:0]          shadow_cols;
   logic                      shadow_mode;
   logic signed [VALUE_W-1:0] shadow_store [STORE_DEPTH];
   int unsigned               shadow_fill;

   placement_type due_placements [$];
   placement_type new_placements [$];

   int fail_count;
   int values_sent;
   int matrices_done;
   int responses_seen;
   int writes_done;
   int burst_left;
   bit sender_live;

   // Clamp a dimension register the way the block reads it
   function automatic int unsigned eff_dim(logic [DIM_W-1:0] raw, int unsigned limit);
      if (raw == 0) return 1;
      if (32'(raw) > limit) return limit;
      return 32'(raw);
   endfunction

   function automatic void shadow_write(logic [1:0] addr, logic [DIM_W-1:0] data);
      case (addr)
         REG_ROW_COUNT: shadow_rows = data;
         REG_COL_COUNT: shadow_cols = data;
         REG_FILL_MODE: shadow_mode = data[0];
         default: return;
      endcase
      shadow_fill = 0;
   endfunction

   // Store one value; on the closing value sort the load and place it snake-wise
   function automatic void load_and_place(logic [31:0] v);
      int unsigned rows, cols, total, r, c, lane, j;
      logic signed [VALUE_W-1:0] sorted [STORE_DEPTH];
      logic signed [VALUE_W-1:0] hold;
      placement_type p;
      new_placements.delete();
      rows  = eff_dim(shadow_rows, MAX_ROWS);
      cols  = eff_dim(shadow_cols, MAX_COLS);
      total = rows * cols;
      shadow_store[shadow_fill] = v;
      shadow_fill++;
      if (shadow_fill < total) return;
      shadow_fill = 0;
      matrices_done++;
      for (int unsigned i = 0; i < total; i++) begin
         hold = shadow_store[i];
         j = i;
         while (j > 0 && sorted[j-1] > hold) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = hold;
      end
      for (int unsigned k = 0; k < total; k++) begin
         if (shadow_mode == MODE_ROWS) begin
            lane = k % cols;
            r = k / cols;
            c = (r % SNAKE_PERIOD == 0) ? lane : cols - 1 - lane;
         end else begin
            lane = k % rows;
            c = k / rows;
            r = (c % SNAKE_PERIOD == 0) ? lane : rows - 1 - lane;
         end
         p.value = sorted[k];
         p.row   = r[POS_W-1:0];
         p.col   = c[POS_W-1:0];
         p.last  = (k == total - 1);
         new_placements.push_back(p);
      end
   endfunction

   function automatic stim_row_type reg_write(logic [1:0] addr, logic [DIM_W-1:0] data);
      stim_row_type s;
      s = '{STIM_WRITE, addr, data, 32'h0, 1'b0, '0};
      return s;
   endfunction

   function automatic stim_row_type plain_value(logic [31:0] v);
      stim_row_type s;
      s = '{STIM_VALUE, 2'd0, '0, v, 1'b0, '0};
      return s;
   endfunction

   // On a 1x1 matrix every request comes straight back at row 0, column 0, last set
   function automatic stim_row_type single_value(logic [31:0] v);
      stim_row_type s;
      s = '{STIM_VALUE, 2'd0, '0, v, 1'b1, '{v, 3'd0, 3'd0, 1'b1}};
      return s;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1: return 32'($urandom_range(0, 4)) - 32'd2;   // small, many duplicates
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      if ($urandom_range(0, 4) == 0) return DIM_W'($urandom_range(0, 15));
      return DIM_W'($urandom_range(1, 4));
   endfunction

   // Present one request, wait for it to be taken, then maybe open a gap.
   // Called and returns at a falling edge.
   task automatic send_value(input logic [31:0] v, input bit fixed,
                             input placement_type fixed_res);
      req_tvalid  <= 1'b1;
      req_tdata   <= v;
      sender_live = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      values_sent++;
      load_and_place(v);
      if (fixed) due_placements.push_back(fixed_res);
      else foreach (new_placements[k]) due_placements.push_back(new_placements[k]);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid  <= 1'b0;
         sender_live = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drop_sender();
      if (sender_live) begin
         req_tvalid  <= 1'b0;
         sender_live = 1'b0;
         @(negedge clock);
      end
   endtask

   // Hold off until every response is in and the insertion walk is surely done
   task automatic settle();
      drop_sender();
      while (due_placements.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [DIM_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      shadow_write(addr, data);
      writes_done++;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Response side stalls on its own pattern, with stretches of steady ready
   ready_style_type ready_style;
   logic [15:0]     ready_pattern;
   int              ready_span = 0;

   always @(negedge clock) begin
      if (ready_span == 0) begin
         ready_span    = $urandom_range(16, 48);
         ready_style   = ready_style_type'($urandom_range(0, 3));
         ready_pattern = 16'($urandom) | 16'h0001;
      end
      ready_span--;
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      case (ready_style)
         READY_ALWAYS:  rsp_tready <= 1'b1;
         READY_PATTERN: rsp_tready <= ready_pattern[0];
         READY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         default:       rsp_tready <= ready_pattern[0] | ready_pattern[1];
      endcase
   end

   // Compare each response with the oldest placement still due
   always @(posedge clock) begin
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (due_placements.size() == 0) begin
            $error("response with nothing due: value_res %0d row %0d col %0d",
                   $signed(rsp_tdata[31:0]), rsp_tdata[34:32], rsp_tdata[37:35]);
            fail_count++;
         end else begin
            want = due_placements.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $error("value_res: expected %0d, got %0d", want.value, $signed(rsp_tdata[31:0]));
               fail_count++;
            end
            if (rsp_tdata[34:32] !== want.row) begin
               $error("row: expected %0d, got %0d", want.row, rsp_tdata[34:32]);
               fail_count++;
            end
            if (rsp_tdata[37:35] !== want.col) begin
               $error("col: expected %0d, got %0d", want.col, rsp_tdata[37:35]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Abort when nothing moves on any port for too long
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d responses due",
                     quiet_cycles, due_placements.size());
            $display("[sort_then_snake_fill] ERROR");
            $finish;
         end
      end
   end

   stim_row_type directed [$];

   initial begin
      int unsigned total, random_sent, phase;
      logic [DIM_W-1:0] rows_w, cols_w;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_addr    = REG_ROW_COUNT;
      csr_wdata   = '0;
      sender_live = 1'b0;
      burst_left  = 0;
      shadow_rows = 4'd1;
      shadow_cols = 4'd1;
      shadow_mode = MODE_ROWS;
      shadow_fill = 0;

      directed = {
         // reset leaves a 1x1 matrix: each request answers itself
         single_value(32'h8000_0000),
         single_value(32'h7FFF_FFFF),
         single_value(32'h0000_0000),
         single_value(32'hFFFF_FFFF),
         // zero dimensions read as one
         reg_write(REG_ROW_COUNT, 4'd0),
         reg_write(REG_COL_COUNT, 4'd0),
         single_value(32'h5555_AAAA),
         // 2x3 along rows, extremes and a duplicate
         reg_write(REG_ROW_COUNT, 4'd2),
         reg_write(REG_COL_COUNT, 4'd3),
         plain_value(32'd3),
         plain_value(32'hFFFF_FFFF),
         plain_value(32'h7FFF_FFFF),
         plain_value(32'h8000_0000),
         plain_value(32'd3),
         plain_value(32'd0),
         // columns mode; bit 0 alone selects it
         reg_write(REG_FILL_MODE, 4'hF),
         plain_value(32'd7),
         plain_value(32'd1),
         // unused index leaves the partial load alone
         reg_write(REG_UNUSED, 4'hA),
         plain_value(32'd2),
         // a real write drops the three values loaded so far
         reg_write(REG_ROW_COUNT, 4'd2),
         plain_value(32'hC000_0000),
         plain_value(32'd9),
         plain_value(32'h4000_0000),
         plain_value(32'd9),
         plain_value(32'hFFFF_FFFE),
         plain_value(32'd0)
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed[i]) begin
         if (directed[i].kind == STIM_WRITE) begin
            settle();
            write_reg(directed[i].addr, directed[i].wdata);
         end else begin
            send_value(directed[i].value, directed[i].fixed, directed[i].fixed_res);
         end
      end

      // random phases: new shape and mode, a few matrices, sometimes a dropped partial
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_VALUES) begin
         case (phase)
            0: begin rows_w = 4'd15; cols_w = 4'd15; end   // clamps to the full 8x8
            1: begin rows_w = 4'd8;  cols_w = 4'd1;  end
            2: begin rows_w = 4'd1;  cols_w = 4'd9;  end
            default: begin rows_w = pick_dim(); cols_w = pick_dim(); end
         endcase
         settle();
         if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, DIM_W'($urandom));
         write_reg(REG_ROW_COUNT, rows_w);
         write_reg(REG_COL_COUNT, cols_w);
         write_reg(REG_FILL_MODE, DIM_W'($urandom));
         total = eff_dim(rows_w, MAX_ROWS) * eff_dim(cols_w, MAX_COLS);
         repeat ((total > 16) ? 1 : $urandom_range(1, 3)) begin
            for (int unsigned k = 0; k < total; k++) begin
               // now and then let every response drain before the next request
               if ($urandom_range(0, 29) == 0) begin
                  drop_sender();
                  while (due_placements.size() != 0) @(negedge clock);
               end
               send_value(random_value(), 1'b0, '0);
               random_sent++;
            end
         end
         if (total > 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, total - 1)) begin
               send_value(random_value(), 1'b0, '0);
               random_sent++;
            end
         end
         phase++;
      end

      drop_sender();
      while (due_placements.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d requests in %0d full matrices, %0d responses checked",
               values_sent, matrices_done, responses_seen);
      $display("%0d register writes over %0d random shapes, both fill modes", writes_done, phase);
      if (fail_count == 0) begin
         $display("[sort_then_snake_fill] OK");
      end else begin
         $display("[sort_then_snake_fill] ERROR");
      end
      $finish;
   end

endmodule
